FILE: rtl/hysteretic_smoothstep_map_defines.svh
// ----------------------------------------------------------------------------
// hysteretic_smoothstep_map_defines.svh
// Assertion macros shared by the smoothstep map RTL
// ----------------------------------------------------------------------------
`ifndef HYSTERETIC_SMOOTHSTEP_MAP_DEFINES_SVH
`define HYSTERETIC_SMOOTHSTEP_MAP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define HSSM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define HSSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/hssm_pkg.sv
// ----------------------------------------------------------------------------
// hssm_pkg
// Shared widths, codes and types of the hysteretic smoothstep map
// ----------------------------------------------------------------------------
package hssm_pkg;

  // input sample and bound width, signed Q16.16
  localparam int IN_W = 32;
  // widened operand width for scaled bounds (10x, 11*hi, 3*hi+lo)
  localparam int OP_W = 38;
  // divider dividend / divisor width
  localparam int DIV_W = 37;

  // result level, unsigned Q1.16
  localparam int LEVEL_W = 17;
  localparam int LEVEL_FRAC = 16;
  localparam logic [LEVEL_W-1:0] LEVEL_ONE = 17'd65536;
  localparam logic [LEVEL_W-1:0] LEVEL_ZERO = 17'd0;

  // shape mode codes
  localparam logic [1:0] MODE_PLAIN = 2'd0;
  localparam logic [1:0] MODE_BINARY = 2'd1;
  localparam logic [1:0] MODE_HYST = 2'd2;
  localparam logic [1:0] MODE_RESET = MODE_HYST;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

FILE: rtl/hysteretic_smoothstep_map.sv
// ----------------------------------------------------------------------------
// hysteretic_smoothstep_map
// Falling cubic smoothstep with optional binary or cubic hysteresis
// ----------------------------------------------------------------------------
// One item at a time. An item whose level saturates, or any item in binary
// mode, goes through the PREP, CHECK and DONE states and then has its result
// loaded into the output register; an item that falls inside the band goes
// through the restoring divider, which produces one bit of t = (x - lo) /
// (hi - lo) per cycle, followed by two passes through one shared
// FRAC_BITS-square multiplier for t^2 and t^3. in_ready is high only while
// the sequencer is idle, which it reaches when the result is loaded, so no
// new item is taken before the result of the previous one is loaded. A
// finished result waits in the output register, so the next item can be
// taken while the previous result is still unclaimed; a second finished
// result stalls the sequencer until the first is taken. shape_mode resets
// to 2; writes do not touch the hysteresis flags.
`include "hysteretic_smoothstep_map_defines.svh"

module hysteretic_smoothstep_map #(
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_wr_en,
  input  logic [1:0]                     cfg_wr_data,
  // input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [31:0]             in_sample_value,
  input  logic signed [31:0]             in_lower_bound,
  input  logic signed [31:0]             in_upper_bound,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [16:0]                    out_level,
  output logic                           out_hysteresis_on
);

  localparam int OPW = hssm_pkg::OP_W;
  localparam int DW  = hssm_pkg::DIV_W;
  localparam int LW  = hssm_pkg::LEVEL_W;
  localparam int FW  = FRAC_BITS + 4;
  localparam int RW  = FRAC_BITS + hssm_pkg::LEVEL_FRAC + 2;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_PREP  = 9'b000000010,
    ST_CHECK = 9'b000000100,
    ST_DIV   = 9'b000001000,
    ST_MUL1  = 9'b000010000,
    ST_MUL2  = 9'b000100000,
    ST_FIN   = 9'b001000000,
    ST_RND   = 9'b010000000,
    ST_DONE  = 9'b100000000
  } state_t;

  state_t                      state_r, state_nxt;
  logic [1:0]                  mode_r, mode_nxt;
  logic                        bin_on_r, bin_on_nxt;
  logic                        cub_on_r, cub_on_nxt;
  logic                        out_valid_r, out_valid_nxt;

  logic signed [31:0]          x_r, lo_r, hi_r;
  logic signed [OPW-1:0]       ax_r, alo_r, ahi_r;
  logic signed [OPW-1:0]       ax_nxt, alo_nxt, ahi_nxt;
  logic [LW-1:0]               level_r, level_nxt;
  logic                        flag_r, flag_nxt;
  logic [FRAC_BITS-1:0]        t2_r, t3_r;
  logic [FRAC_BITS:0]          f_r, f_nxt;
  logic [LW-1:0]               out_level_r;
  logic                        out_flag_r;

  logic signed [OPW-1:0]       sx, slo, shi;
  logic signed [OPW-1:0]       diff_d, diff_s;
  logic                        ge_hi, gt_hi, le_lo, lt_lo, bin_new;
  logic                        div_start;
  hssm_pkg::div_sts_t          div_sts;
  logic [FRAC_BITS-1:0]        t_q;
  logic [FRAC_BITS-1:0]        mul_b;
  logic [2*FRAC_BITS-1:0]      prod;
  logic signed [FW-1:0]        f_one, f_t2, f_t3, f_sum;
  logic [RW-1:0]               rnd_sum, rnd_shr;
  logic                        out_load;

  // restoring divider
  hssm_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (diff_d[DW-1:0]),
    .divisor  (diff_s[DW-1:0]),
    .sts      (div_sts),
    .quotient (t_q)
  );

  // widen the latched item
  always_comb begin
    sx  = {{(OPW-32){x_r[31]}}, x_r};
    slo = {{(OPW-32){lo_r[31]}}, lo_r};
    shi = {{(OPW-32){hi_r[31]}}, hi_r};
  end

  // scaled operands per mode
  always_comb begin
    cub_on_nxt = cub_on_r;
    case (mode_r)
      hssm_pkg::MODE_BINARY: begin
        ax_nxt  = (sx <<< 3) + (sx <<< 1);
        alo_nxt = (shi <<< 3) + shi;
        ahi_nxt = (shi <<< 3) + (shi <<< 1) + shi;
      end
      hssm_pkg::MODE_HYST: begin
        ax_nxt = sx <<< 2;
        if (cub_on_r) begin
          alo_nxt = slo <<< 2;
          ahi_nxt = (shi <<< 1) + shi + slo;
          if (x_r > hi_r) cub_on_nxt = 1'b0;
        end else begin
          alo_nxt = (slo <<< 1) + slo + shi;
          ahi_nxt = shi <<< 2;
          if (x_r < lo_r) cub_on_nxt = 1'b1;
        end
      end
      default: begin
        ax_nxt  = sx;
        alo_nxt = slo;
        ahi_nxt = shi;
      end
    endcase
  end

  // band compares and division operands
  always_comb begin
    ge_hi   = (ax_r >= ahi_r);
    gt_hi   = (ax_r > ahi_r);
    le_lo   = (ax_r <= alo_r);
    lt_lo   = (ax_r < alo_r);
    diff_d  = ax_r - alo_r;
    diff_s  = ahi_r - alo_r;
    bin_new = bin_on_r ? !gt_hi : lt_lo;
  end

  // shared multiplier: t*t, then t2*t
  assign mul_b = (state_r == ST_MUL1) ? t_q : t2_r;
  assign prod  = t_q * mul_b;

  // cubic combine and clamp
  always_comb begin
    f_one = FW'(1) <<< FRAC_BITS;
    f_t2  = $signed({4'b0, t2_r});
    f_t3  = $signed({4'b0, t3_r});
    f_sum = f_one - ((f_t2 <<< 1) + f_t2) + (f_t3 <<< 1);
    if (f_sum < 0) begin
      f_nxt = '0;
    end else if (f_sum > f_one) begin
      f_nxt = f_one[FRAC_BITS:0];
    end else begin
      f_nxt = f_sum[FRAC_BITS:0];
    end
  end

  // rescale to Q1.16 with round half up
  always_comb begin
    rnd_sum = {1'b0, f_r, {hssm_pkg::LEVEL_FRAC{1'b0}}} + (RW'(1) << (FRAC_BITS - 1));
    rnd_shr = rnd_sum >> FRAC_BITS;
  end

  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    bin_on_nxt = bin_on_r;
    level_nxt  = level_r;
    flag_nxt   = flag_r;
    div_start  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_PREP;
      end
      ST_PREP: begin
        flag_nxt  = (mode_r == hssm_pkg::MODE_HYST) ? cub_on_nxt : 1'b0;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (mode_r == hssm_pkg::MODE_BINARY) begin
          bin_on_nxt = bin_new;
          flag_nxt   = bin_new;
          level_nxt  = bin_new ? hssm_pkg::LEVEL_ONE : hssm_pkg::LEVEL_ZERO;
          state_nxt  = ST_DONE;
        end else if (ge_hi) begin
          level_nxt = hssm_pkg::LEVEL_ZERO;
          state_nxt = ST_DONE;
        end else if (le_lo) begin
          level_nxt = hssm_pkg::LEVEL_ONE;
          state_nxt = ST_DONE;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_sts.done) state_nxt = ST_MUL1;
      end
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_FIN;
      ST_FIN:  state_nxt = ST_RND;
      ST_RND: begin
        if (rnd_shr > RW'(hssm_pkg::LEVEL_ONE)) begin
          level_nxt = hssm_pkg::LEVEL_ONE;
        end else begin
          level_nxt = rnd_shr[LW-1:0];
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // config register and output valid
  always_comb begin
    mode_nxt = cfg_wr_en ? cfg_wr_data : mode_r;
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= hssm_pkg::MODE_RESET;
      bin_on_r    <= 1'b1;
      cub_on_r    <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      bin_on_r    <= bin_on_nxt;
      cub_on_r    <= (state_r == ST_PREP) ? cub_on_nxt : cub_on_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      x_r  <= in_sample_value;
      lo_r <= in_lower_bound;
      hi_r <= in_upper_bound;
    end
    if (state_r == ST_PREP) begin
      ax_r  <= ax_nxt;
      alo_r <= alo_nxt;
      ahi_r <= ahi_nxt;
    end
    if (state_r == ST_MUL1) t2_r <= prod[2*FRAC_BITS-1:FRAC_BITS];
    if (state_r == ST_MUL2) t3_r <= prod[2*FRAC_BITS-1:FRAC_BITS];
    if (state_r == ST_FIN) f_r <= f_nxt;
    level_r <= level_nxt;
    flag_r  <= flag_nxt;
    if (out_load) begin
      out_level_r <= level_r;
      out_flag_r  <= flag_r;
    end
  end

  assign in_ready          = (state_r == ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_level         = out_level_r;
  assign out_hysteresis_on = out_flag_r;

  // checks
  `HSSM_ASSERT_NEXT(a_accept_to_prep, in_valid && in_ready, state_r == ST_PREP, "accepted item did not start the sequence")
  `HSSM_ASSERT_NOW(a_level_range, out_valid, out_level <= hssm_pkg::LEVEL_ONE, "level above 1.0")
  `HSSM_ASSERT_NOW(a_div_owned, div_sts.busy, state_r == ST_DIV, "divider running outside its state")

endmodule

FILE: rtl/hssm_div.sv
// ----------------------------------------------------------------------------
// hssm_div
// Restoring divider: one quotient bit per cycle, fraction of a proper ratio
// ----------------------------------------------------------------------------
module hssm_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [hssm_pkg::DIV_W-1:0]  dividend,
  input  logic [hssm_pkg::DIV_W-1:0]  divisor,
  output hssm_pkg::div_sts_t          sts,
  output logic [FRAC_BITS-1:0]        quotient
);

  localparam int CW = $clog2(FRAC_BITS + 1);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic [hssm_pkg::DIV_W-1:0]  rem_r, rem_nxt;
  logic [hssm_pkg::DIV_W-1:0]  dsr_r, dsr_nxt;
  logic [FRAC_BITS-1:0]        quo_r, quo_nxt;
  logic [hssm_pkg::DIV_W:0]    rem_dbl;
  logic [hssm_pkg::DIV_W:0]    rem_sub;
  logic                        q_bit;

  // one restoring step: shift remainder, trial subtract
  always_comb begin
    rem_dbl = {rem_r, 1'b0};
    rem_sub = rem_dbl - {1'b0, dsr_r};
    q_bit   = (rem_dbl >= {1'b0, dsr_r});
  end

  // step control
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(FRAC_BITS);
      rem_nxt  = dividend;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = q_bit ? rem_sub[hssm_pkg::DIV_W-1:0] : rem_dbl[hssm_pkg::DIV_W-1:0];
      quo_nxt = {quo_r[FRAC_BITS-2:0], q_bit};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    quo_r <= quo_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = quo_r;

endmodule

FILE: tb/sv/hysteretic_smoothstep_map_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hysteretic_smoothstep_map_checker
// Watches the configuration, input and result channels of the smoothstep
// map. It keeps its own copy of the shape mode and both hysteresis flags,
// works out the level of every accepted item and compares each accepted
// result with the oldest level still owed.
// ----------------------------------------------------------------------------
module hysteretic_smoothstep_map_checker #(
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [1:0]                     cfg_wr_data,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic signed [31:0]             in_sample_value,
  input  logic signed [31:0]             in_lower_bound,
  input  logic signed [31:0]             in_upper_bound,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [hssm_pkg::LEVEL_W-1:0]   out_level,
  input  logic                           out_hysteresis_on,
  output int                             error_count,
  output int                             results_seen,
  output int                             levels_waiting
);

  typedef struct packed {
    logic [hssm_pkg::LEVEL_W-1:0] level;
    logic                         hyst_on;
  } map_result_t;

  map_result_t owed_levels[$];
  logic [1:0]  shape_mode;
  logic        binary_on;
  logic        cubic_on;

  // falling cubic 1 - 3t^2 + 2t^3 over the band, in Q1.16
  function automatic logic [hssm_pkg::LEVEL_W-1:0] falling_level(longint x, longint lo,
                                                                 longint hi);
    longint unsigned d, s, t, t2, t3, lv;
    longint          f, one;
    one = longint'(1) <<< FRAC_BITS;
    if (x >= hi) return hssm_pkg::LEVEL_ZERO;
    if (x <= lo) return hssm_pkg::LEVEL_ONE;
    d  = unsigned'(x - lo);
    s  = unsigned'(hi - lo);
    t  = (d << FRAC_BITS) / s;
    t2 = (t * t) >> FRAC_BITS;
    t3 = (t2 * t) >> FRAC_BITS;
    f  = one - 3 * longint'(t2) + 2 * longint'(t3);
    if (f < 0) f = 0;
    if (f > one) f = one;
    lv = (unsigned'(f) * 65536 + unsigned'(one >>> 1)) >> FRAC_BITS;
    if (lv > 65536) lv = 65536;
    return lv[hssm_pkg::LEVEL_W-1:0];
  endfunction

  // level and flag of one item, advancing the flag of the active mode
  function automatic map_result_t map_sample(longint x, longint lo, longint hi);
    map_result_t r;
    r.hyst_on = 1'b0;
    if (shape_mode == hssm_pkg::MODE_BINARY) begin
      if (binary_on) binary_on = !(10 * x > 11 * hi);
      else binary_on = (10 * x < 9 * hi);
      r.level   = binary_on ? hssm_pkg::LEVEL_ONE : hssm_pkg::LEVEL_ZERO;
      r.hyst_on = binary_on;
    end else if (shape_mode == hssm_pkg::MODE_HYST) begin
      if (cubic_on) begin
        r.level = falling_level(4 * x, 4 * lo, 3 * hi + lo);
        if (x > hi) cubic_on = 1'b0;
      end else begin
        r.level = falling_level(4 * x, 3 * lo + hi, 4 * hi);
        if (x < lo) cubic_on = 1'b1;
      end
      r.hyst_on = cubic_on;
    end else begin
      // plain cubic, spare code included; flags untouched
      r.level = falling_level(x, lo, hi);
    end
    return r;
  endfunction

  // predict on input items, compare on result items, follow config writes
  always @(posedge clk) begin
    map_result_t want;
    if (!rst_n) begin
      shape_mode = hssm_pkg::MODE_RESET;
      binary_on  = 1'b1;
      cubic_on   = 1'b1;
      owed_levels.delete();
    end else begin
      if (in_valid && in_ready) begin
        owed_levels.push_back(map_sample(in_sample_value, in_lower_bound, in_upper_bound));
      end
      if (out_valid && out_ready) begin
        results_seen = results_seen + 1;
        if (owed_levels.size() == 0) begin
          error_count = error_count + 1;
          if (error_count <= 10)
            $display("%0t: result with nothing owed: level=%0d hyst_on=%0b",
                     $realtime, out_level, out_hysteresis_on);
        end else begin
          want = owed_levels.pop_front();
          if (out_level !== want.level || out_hysteresis_on !== want.hyst_on) begin
            error_count = error_count + 1;
            if (error_count <= 10)
              $display("%0t: mismatch: level exp=%0d act=%0d, hyst_on exp=%0b act=%0b",
                       $realtime, want.level, out_level, want.hyst_on, out_hysteresis_on);
          end
        end
      end
      if (cfg_wr_en) shape_mode = cfg_wr_data;
    end
    levels_waiting = owed_levels.size();
  end

endmodule

FILE: tb/sv/hysteretic_smoothstep_map_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hysteretic_smoothstep_map_tb
// Drives the smoothstep map with directed corner items and then random
// bands and samples under every shape mode, with random idling on both
// channels and one long result stall. A checker beside the block predicts
// and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module hysteretic_smoothstep_map_tb;

  localparam int     FRAC_BITS  = 16;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam longint S32_MIN    = -(longint'(1) <<< 31);
  localparam longint S32_MAX    = (longint'(1) <<< 31) - 1;
  localparam int     RANDOM_PER_PHASE = 250;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic [1:0]         cfg_wr_data = 2'd0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] in_sample_value = '0;
  logic signed [31:0] in_lower_bound = '0;
  logic signed [31:0] in_upper_bound = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [16:0]        out_level;
  logic               out_hysteresis_on;

  int         error_count;
  int         results_seen;
  int         levels_waiting;
  int         items_sent = 0;
  int         tx_idle_pct = 19;
  int         rx_idle_pct = 77;
  logic       rx_hold = 1'b0;
  logic [1:0] cur_mode = hssm_pkg::MODE_RESET;

  hysteretic_smoothstep_map #(.FRAC_BITS(FRAC_BITS)) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample_value   (in_sample_value),
    .in_lower_bound    (in_lower_bound),
    .in_upper_bound    (in_upper_bound),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_level         (out_level),
    .out_hysteresis_on (out_hysteresis_on)
  );

  hysteretic_smoothstep_map_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample_value   (in_sample_value),
    .in_lower_bound    (in_lower_bound),
    .in_upper_bound    (in_upper_bound),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_level         (out_level),
    .out_hysteresis_on (out_hysteresis_on),
    .error_count       (error_count),
    .results_seen      (results_seen),
    .levels_waiting    (levels_waiting)
  );

  // clock
  initial begin
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #8_000_000;
    $display("hysteretic_smoothstep_map verification failed");
    $finish;
  end

  // result side readiness
  always @(posedge clk) begin
    out_ready <= rx_hold ? 1'b0 : ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // long result stall once idling is off, so the input backs up
  initial begin
    wait (items_sent >= 1500);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (300) @(posedge clk);
    rx_hold <= 1'b0;
  end

  function automatic longint corner_value();
    case ($urandom_range(0, 5))
      0: return S32_MIN;
      1: return S32_MAX;
      2: return 0;
      3: return -1;
      4: return 1;
      default: return 65536;
    endcase
  endfunction

  function automatic longint clamp32(longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  // offer one item, after a random gap, and hold it until taken
  task automatic send_item(longint x, longint lo, longint hi);
    if (items_sent < 700) begin
      tx_idle_pct = 19;
      rx_idle_pct <= 77;
    end else if (items_sent < 1400) begin
      tx_idle_pct = 77;
      rx_idle_pct <= 19;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct <= 0;
    end
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_sample_value <= x[31:0];
    in_lower_bound  <= lo[31:0];
    in_upper_bound  <= hi[31:0];
    do @(posedge clk); while (!in_ready);
    items_sent = items_sent + 1;
  endtask

  // mode write once every owed result is back
  task automatic write_mode(logic [1:0] mode);
    in_valid <= 1'b0;
    while (results_seen != items_sent) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_mode = mode;
  endtask

  // random band and sample, mostly well formed and near the band
  task automatic random_item(output longint x, output longint lo, output longint hi);
    int              kind;
    longint          span, off, tmp;
    longint unsigned r;
    kind = $urandom_range(0, 9);
    r    = {$urandom, $urandom};
    if (kind == 0) begin
      x  = int'($urandom);
      lo = int'($urandom);
      hi = int'($urandom);
    end else if (kind == 1) begin
      x  = corner_value();
      lo = corner_value();
      hi = corner_value();
    end else begin
      lo   = int'($urandom) >>> $urandom_range(0, 20);
      span = longint'(1) + longint'($urandom >> $urandom_range(0, 31));
      hi   = lo + span;
      if (hi > S32_MAX) begin
        hi = S32_MAX;
        lo = clamp32(hi - span);
        span = hi - lo;
      end
      if (cur_mode == hssm_pkg::MODE_BINARY && kind > 4) begin
        off = (hi < 0 ? -hi : hi) / 4 + 16;
        x   = hi - off + longint'(r % unsigned'(2 * off + 1));
      end else begin
        x = lo - span / 2 + longint'(r % unsigned'(2 * span + 1));
      end
      x = clamp32(x);
      // inverted band now and then
      if (kind == 2) begin
        tmp = lo;
        lo  = hi;
        hi  = tmp;
      end
    end
  endtask

  task automatic random_phase(logic [1:0] mode);
    longint x, lo, hi;
    write_mode(mode);
    repeat (RANDOM_PER_PHASE) begin
      random_item(x, lo, hi);
      send_item(x, lo, hi);
    end
  endtask

  // stimulus and verdict
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // cubic with hysteresis from the reset mode: flag falls above hi, rises below lo
    send_item(-65536, 0, 65536);
    send_item(20000, 0, 65536);
    send_item(70000, 0, 65536);
    send_item(40000, 0, 65536);
    send_item(-1, 0, 65536);
    send_item(5, 10, 10);
    send_item(S32_MIN, S32_MAX, S32_MIN);
    send_item(S32_MAX, S32_MIN, S32_MAX);

    // plain cubic: band edges, inverted bands, widest band
    write_mode(hssm_pkg::MODE_PLAIN);
    send_item(0, 0, 65536);
    send_item(65536, 0, 65536);
    send_item(32768, 0, 65536);
    send_item(300, 200, 100);
    send_item(50, 200, 100);
    send_item(S32_MAX - 1, S32_MIN, S32_MAX);
    send_item(S32_MIN + 1, S32_MIN, S32_MAX);

    // binary switch: exact thresholds, positive and negative hi, extremes
    write_mode(hssm_pkg::MODE_BINARY);
    send_item(11000, 0, 10000);
    send_item(11001, 0, 10000);
    send_item(9000, 0, 10000);
    send_item(8999, 0, 10000);
    send_item(0, 0, -10000);
    send_item(-9001, 0, -10000);
    send_item(S32_MAX, S32_MAX, S32_MIN);
    send_item(S32_MIN, S32_MIN, S32_MAX);

    // spare mode code acts as the plain cubic
    write_mode(MODE_SPARE);
    send_item(16384, 0, 65536);
    send_item(S32_MAX, S32_MIN, S32_MIN);

    random_phase(hssm_pkg::MODE_PLAIN);
    random_phase(hssm_pkg::MODE_HYST);
    random_phase(hssm_pkg::MODE_BINARY);
    random_phase(MODE_SPARE);
    random_phase(hssm_pkg::MODE_HYST);
    random_phase(hssm_pkg::MODE_BINARY);
    random_phase(hssm_pkg::MODE_PLAIN);
    random_phase(hssm_pkg::MODE_HYST);

    in_valid <= 1'b0;
    while (results_seen != items_sent) @(posedge clk);
    repeat (30) @(posedge clk);
    if (error_count == 0 && levels_waiting == 0) begin
      $display("hysteretic_smoothstep_map verification clean");
    end else begin
      $display("hysteretic_smoothstep_map verification failed");
    end
    $finish;
  end

endmodule
